@@ hdl/ofv_pkg.sv @@
// Shared constants and types for the orthonormal frame block.
package ofv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int SQA_W     = 2 * DW;
    localparam int SA_W      = SQA_W + 2;
    localparam int XW        = 2 * DW;
    localparam int SQX_W     = 2 * XW;
    localparam int SX_W      = SQX_W + 2;
    localparam int ML_W      = 16;
    localparam int LIM_W     = 2 * ML_W;
    localparam int NORM_W    = SX_W + 64;
    localparam int TGT_SHIFT = 62;
    localparam int Q_W       = 32;
    localparam int NSTG      = Q_W;
    localparam int NCOL      = 9;

    localparam logic [ML_W-1:0] ML_RESET = 16'd66;

    typedef struct packed {
        logic [2:0]             sgn_a;
        logic [2:0][SQA_W-1:0]  sq_a;
        logic [SA_W-1:0]        s_a;
        logic                   ok_a;
        logic [2:0]             sgn_x;
        logic [2:0][SQX_W-1:0]  sq_x;
        logic [SX_W-1:0]        s_x;
        logic                   ok_x;
    } t_job;

    typedef struct packed {
        logic [2:0] sgn_a;
        logic [2:0] sgn_x;
        logic       ok_a;
        logic       ok_x;
    } t_meta;

endpackage

@@ hdl/ofv_front.sv @@
// Front end: cross product, squared lengths and the length threshold test.
module ofv_front import ofv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic signed [DW-1:0] i_ax,
    input  logic signed [DW-1:0] i_ay,
    input  logic signed [DW-1:0] i_az,
    input  logic signed [DW-1:0] i_bx,
    input  logic signed [DW-1:0] i_by,
    input  logic signed [DW-1:0] i_bz,
    input  logic [ML_W-1:0]      i_min_length,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_q_push,
    output t_job                 o_job
);

    logic signed [DW-1:0] a [3];
    logic signed [DW-1:0] b [3];
    logic                 f_en;
    logic                 take;

    logic [7:1] r_v;

    logic signed [XW-1:0]  r1_p [6];
    logic [2:0]            r1_sgn_a;
    logic [DW-1:0]         r1_mag_a [3];

    logic signed [XW-1:0]  r2_x [3];
    logic [2:0]            r2_sgn_a;
    logic [SQA_W-1:0]      r2_sq_a [3];
    logic [LIM_W-1:0]      r2_lim;

    logic [2:0]            r3_sgn_x;
    logic [XW-1:0]         r3_mag_x [3];
    logic [2:0]            r3_sgn_a;
    logic [SQA_W-1:0]      r3_sq_a [3];
    logic [SA_W-1:0]       r3_s_a;
    logic [LIM_W-1:0]      r3_lim;

    logic [SQA_W-1:0]      r4_hh [3];
    logic [SQA_W-1:0]      r4_hl [3];
    logic [SQA_W-1:0]      r4_ll [3];
    logic [2:0]            r4_sgn_x;
    logic [2:0]            r4_sgn_a;
    logic [SQA_W-1:0]      r4_sq_a [3];
    logic [SA_W-1:0]       r4_s_a;
    logic                  r4_ok_a;
    logic [LIM_W-1:0]      r4_lim;

    logic [SQX_W-1:0]      r5_sq_x [3];
    logic [2:0]            r5_sgn_x;
    logic [2:0]            r5_sgn_a;
    logic [SQA_W-1:0]      r5_sq_a [3];
    logic [SA_W-1:0]       r5_s_a;
    logic                  r5_ok_a;
    logic [LIM_W-1:0]      r5_lim;

    logic [SQX_W-1:0]      r6_sq_x [3];
    logic [SX_W-1:0]       r6_s_x;
    logic [2:0]            r6_sgn_x;
    logic [2:0]            r6_sgn_a;
    logic [SQA_W-1:0]      r6_sq_a [3];
    logic [SA_W-1:0]       r6_s_a;
    logic                  r6_ok_a;
    logic [LIM_W-1:0]      r6_lim;

    t_job                  r7_job;

    assign a[0] = i_ax;
    assign a[1] = i_ay;
    assign a[2] = i_az;
    assign b[0] = i_bx;
    assign b[1] = i_by;
    assign b[2] = i_bz;

    // hold the whole front while a finished word cannot enter the queue
    assign f_en     = !(r_v[7] && i_q_full);
    assign o_full   = !f_en;
    assign take     = i_push && f_en;
    assign o_q_push = r_v[7] && !i_q_full;
    assign o_job    = r7_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (f_en) begin
            r_v <= {r_v[6:1], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r1_p[0] <= a[1] * b[2];
            r1_p[1] <= a[2] * b[1];
            r1_p[2] <= a[2] * b[0];
            r1_p[3] <= a[0] * b[2];
            r1_p[4] <= a[0] * b[1];
            r1_p[5] <= a[1] * b[0];
            for (int i = 0; i < 3; i++) begin
                r1_sgn_a[i] <= a[i][DW-1];
                r1_mag_a[i] <= a[i][DW-1] ? (~a[i] + DW'(1)) : a[i];
            end

            r2_x[0]  <= r1_p[0] - r1_p[1];
            r2_x[1]  <= r1_p[2] - r1_p[3];
            r2_x[2]  <= r1_p[4] - r1_p[5];
            r2_sgn_a <= r1_sgn_a;
            for (int i = 0; i < 3; i++) begin
                r2_sq_a[i] <= SQA_W'(r1_mag_a[i]) * SQA_W'(r1_mag_a[i]);
            end
            r2_lim <= LIM_W'(i_min_length) * LIM_W'(i_min_length);

            for (int i = 0; i < 3; i++) begin
                r3_sgn_x[i] <= r2_x[i][XW-1];
                r3_mag_x[i] <= r2_x[i][XW-1] ? (~r2_x[i] + XW'(1)) : r2_x[i];
            end
            r3_sgn_a <= r2_sgn_a;
            r3_sq_a  <= r2_sq_a;
            r3_s_a   <= SA_W'(r2_sq_a[0]) + SA_W'(r2_sq_a[1]) + SA_W'(r2_sq_a[2]);
            r3_lim   <= r2_lim;

            // split each 64-bit magnitude into 32-bit halves for the square
            for (int i = 0; i < 3; i++) begin
                r4_hh[i] <= SQA_W'(r3_mag_x[i][XW-1:DW]) * SQA_W'(r3_mag_x[i][XW-1:DW]);
                r4_hl[i] <= SQA_W'(r3_mag_x[i][XW-1:DW]) * SQA_W'(r3_mag_x[i][DW-1:0]);
                r4_ll[i] <= SQA_W'(r3_mag_x[i][DW-1:0]) * SQA_W'(r3_mag_x[i][DW-1:0]);
            end
            r4_sgn_x <= r3_sgn_x;
            r4_sgn_a <= r3_sgn_a;
            r4_sq_a  <= r3_sq_a;
            r4_s_a   <= r3_s_a;
            r4_ok_a  <= r3_s_a > SA_W'(r3_lim);
            r4_lim   <= r3_lim;

            for (int i = 0; i < 3; i++) begin
                r5_sq_x[i] <= (SQX_W'(r4_hh[i]) << (2 * DW))
                            + (SQX_W'(r4_hl[i]) << (DW + 1))
                            + SQX_W'(r4_ll[i]);
            end
            r5_sgn_x <= r4_sgn_x;
            r5_sgn_a <= r4_sgn_a;
            r5_sq_a  <= r4_sq_a;
            r5_s_a   <= r4_s_a;
            r5_ok_a  <= r4_ok_a;
            r5_lim   <= r4_lim;

            r6_sq_x  <= r5_sq_x;
            r6_s_x   <= SX_W'(r5_sq_x[0]) + SX_W'(r5_sq_x[1]) + SX_W'(r5_sq_x[2]);
            r6_sgn_x <= r5_sgn_x;
            r6_sgn_a <= r5_sgn_a;
            r6_sq_a  <= r5_sq_a;
            r6_s_a   <= r5_s_a;
            r6_ok_a  <= r5_ok_a;
            r6_lim   <= r5_lim;

            r7_job.sgn_a <= r6_sgn_a;
            r7_job.s_a   <= r6_s_a;
            r7_job.ok_a  <= r6_ok_a;
            r7_job.sgn_x <= r6_sgn_x;
            r7_job.s_x   <= r6_s_x;
            // the cross product carries twice the fraction bits
            r7_job.ok_x  <= r6_s_x > (SX_W'(r6_lim) << (2 * FRAC_BITS));
            for (int i = 0; i < 3; i++) begin
                r7_job.sq_a[i] <= r6_sq_a[i];
                r7_job.sq_x[i] <= r6_sq_x[i];
            end
        end
    end

endmodule

@@ hdl/ofv_jobq.sv @@
// Two-entry queue of classified words between front and back.
module ofv_jobq import ofv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ hdl/ofv_norm.sv @@
// Pipelined bit-per-stage solver for floor(c * 2^31 / sqrt(S)).
module ofv_norm import ofv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NORM_W-1:0] i_s,
    input  logic [NORM_W-1:0] i_t,
    output logic [Q_W-1:0]    o_q
);

    // remainder holds t - q^2 * S, y holds q * S
    logic [NORM_W-1:0] r_rem [NSTG];
    logic [NORM_W-1:0] r_y   [NSTG];
    logic [NORM_W-1:0] r_s   [NSTG];
    logic [Q_W-1:0]    r_q   [NSTG+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_t;
            r_y[0]   <= '0;
            r_s[0]   <= i_s;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int B = NSTG - 1 - k;
        logic [NORM_W-1:0] d;
        logic [NORM_W-1:0] n_rem;
        logic [NORM_W-1:0] n_y;
        logic [Q_W-1:0]    n_q;
        logic              fit;

        always_comb begin
            d     = (r_y[k] << (B + 1)) + (r_s[k] << (2 * B));
            fit   = (d <= r_rem[k]);
            n_rem = fit ? (r_rem[k] - d) : r_rem[k];
            n_y   = fit ? (r_y[k] + (r_s[k] << B)) : r_y[k];
            n_q   = fit ? (r_q[k] | (Q_W'(1) << B)) : r_q[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= n_q;
            end
        end

        if (k < NSTG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_rem;
                    r_y[k+1]   <= n_y;
                    r_s[k+1]   <= r_s[k];
                end
            end
        end
    end

    assign o_q = r_q[NSTG];

endmodule

@@ hdl/ofv_back.sv @@
// Back end: six normalizers, column two and the two-entry result queue.
module ofv_back import ofv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_avail,
    input  t_job                     i_job,
    output logic                     o_job_take,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic [NCOL-1:0][DW-1:0]  o_cols
);

    localparam int LAST = NSTG + 2;

    logic                    b_en;
    logic                    take;
    logic                    enq;
    logic                    deq;
    logic                    oq_full;
    logic [NORM_W-1:0]       n_s [6];
    logic [NORM_W-1:0]       n_t [6];
    logic [Q_W-1:0]          q   [6];
    logic signed [XW-1:0]    d   [3];
    logic signed [XW-1:0]    e   [3];
    logic [NCOL-1:0][DW-1:0] n_word;

    logic [LAST:0]           r_v;
    t_meta                   r_meta [NSTG+1];
    logic signed [DW-1:0]    r_c  [6];
    logic signed [DW-1:0]    r_c2 [6];
    logic signed [XW-1:0]    r_p  [6];
    logic [NCOL-1:0][DW-1:0] r_oq [2];
    logic                    r_wp;
    logic                    r_rp;
    logic [1:0]              r_oq_cnt;

    // stall the whole back end only when the last stage cannot drain
    assign oq_full    = (r_oq_cnt == 2'd2);
    assign b_en       = !(r_v[LAST] && oq_full);
    assign take       = b_en && i_job_avail;
    assign o_job_take = take;
    assign enq        = r_v[LAST] && b_en;
    assign deq        = i_pop && !o_empty;
    assign o_empty    = (r_oq_cnt == 2'd0);
    assign o_cols     = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (b_en) begin
            r_v <= {r_v[LAST-1:0], take};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i]   = NORM_W'(i_job.s_a);
            n_t[i]   = NORM_W'(i_job.sq_a[i]) << TGT_SHIFT;
            n_s[i+3] = NORM_W'(i_job.s_x);
            n_t[i+3] = NORM_W'(i_job.sq_x[i]) << TGT_SHIFT;
        end
    end

    for (genvar i = 0; i < 6; i++) begin : g_norm
        ofv_norm u_norm (
            .i_clk (i_clk),
            .i_en  (b_en),
            .i_s   (n_s[i]),
            .i_t   (n_t[i]),
            .o_q   (q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_meta[0].sgn_a <= i_job.sgn_a;
            r_meta[0].sgn_x <= i_job.sgn_x;
            r_meta[0].ok_a  <= i_job.ok_a;
            r_meta[0].ok_x  <= i_job.ok_x;
            for (int k = 0; k < NSTG; k++) begin
                r_meta[k+1] <= r_meta[k];
            end
        end
    end

    // round half away from zero, apply sign, drop short vectors
    always_ff @(posedge i_clk) begin
        logic [Q_W:0]   rnd;
        logic [DW-1:0]  mag;
        logic           sgn;
        logic           ok;
        if (b_en) begin
            for (int i = 0; i < 6; i++) begin
                rnd = ((Q_W + 1)'(q[i]) + (Q_W + 1)'(1)) >> 1;
                mag = rnd[DW-1:0];
                sgn = (i < 3) ? r_meta[NSTG].sgn_a[i % 3] : r_meta[NSTG].sgn_x[i % 3];
                ok  = (i < 3) ? r_meta[NSTG].ok_a : r_meta[NSTG].ok_x;
                r_c[i] <= !ok ? '0 : (sgn ? (~mag + DW'(1)) : mag);
            end

            r_c2    <= r_c;
            r_p[0]  <= r_c[1] * r_c[5];
            r_p[1]  <= r_c[2] * r_c[4];
            r_p[2]  <= r_c[2] * r_c[3];
            r_p[3]  <= r_c[0] * r_c[5];
            r_p[4]  <= r_c[0] * r_c[4];
            r_p[5]  <= r_c[1] * r_c[3];
        end
    end

    // col2 rounds half toward plus infinity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i] = r_p[2*i] - r_p[2*i+1];
            e[i] = d[i] + XW'(64'sd536870912);
            n_word[3+i] = e[i][61:30];
            n_word[i]   = r_c2[i];
            n_word[6+i] = r_c2[3+i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= !r_wp;
            end
            if (deq) begin
                r_rp <= !r_rp;
            end
            r_oq_cnt <= r_oq_cnt + 2'(enq) - 2'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_oq[r_wp] <= n_word;
        end
    end

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt != 2'd3)
        else $error("result queue count out of range");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && !b_en) |=> r_v[LAST])
        else $error("stalled result dropped from last stage");

    a_short_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG] && b_en && !r_meta[NSTG].ok_a) |=>
        (r_c[0] == 0 && r_c[1] == 0 && r_c[2] == 0))
        else $error("short first vector not zeroed");

    a_short_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG] && b_en && !r_meta[NSTG].ok_x) |=>
        (r_c[3] == 0 && r_c[4] == 0 && r_c[5] == 0))
        else $error("short cross product not zeroed");
`endif

endmodule

@@ hdl/orthonormal_frame_from_two_vectors.sv @@
// Top level: orthonormal frame from two vectors, front, word queue and back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  input    | in        | push / full        | i_first_*, i_second_* (Q16.16)
//  result   | out       | pop / empty        | o_col1_*, o_col2_*, o_col3_* (Q2.30)
//  config   | in        | i_cfg_valid / rdy  | i_min_length
//
// One word per cycle sustained unless a full queue stalls; 7 front stages, the
// word queue, 32 normalizer stages (one quotient bit each) and finishing stages.
// Reset is synchronous, active low, and sets min_length to 66.
// A stalled result holds the back end; the front fills the word queue, then holds.
module orthonormal_frame_from_two_vectors import ofv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [DW-1:0] i_first_x,
    input  logic signed [DW-1:0] i_first_y,
    input  logic signed [DW-1:0] i_first_z,
    input  logic signed [DW-1:0] i_second_x,
    input  logic signed [DW-1:0] i_second_y,
    input  logic signed [DW-1:0] i_second_z,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [DW-1:0] o_col1_x,
    output logic signed [DW-1:0] o_col1_y,
    output logic signed [DW-1:0] o_col1_z,
    output logic signed [DW-1:0] o_col2_x,
    output logic signed [DW-1:0] o_col2_y,
    output logic signed [DW-1:0] o_col2_z,
    output logic signed [DW-1:0] o_col3_x,
    output logic signed [DW-1:0] o_col3_y,
    output logic signed [DW-1:0] o_col3_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ML_W-1:0]      i_min_length
);

    logic [ML_W-1:0]         r_min_length;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_push;
    logic                    q_pop;
    t_job                    f_job;
    t_job                    b_job;
    logic [NCOL-1:0][DW-1:0] cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= ML_RESET;
        end else if (i_cfg_valid) begin
            r_min_length <= i_min_length;
        end
    end

    ofv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_ax         (i_first_x),
        .i_ay         (i_first_y),
        .i_az         (i_first_z),
        .i_bx         (i_second_x),
        .i_by         (i_second_y),
        .i_bz         (i_second_z),
        .i_min_length (r_min_length),
        .i_q_full     (q_full),
        .o_full       (full),
        .o_q_push     (q_push),
        .o_job        (f_job)
    );

    ofv_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (b_job)
    );

    ofv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!q_empty),
        .i_job       (b_job),
        .o_job_take  (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_cols      (cols)
    );

    assign o_col1_x = cols[0];
    assign o_col1_y = cols[1];
    assign o_col1_z = cols[2];
    assign o_col2_x = cols[3];
    assign o_col2_y = cols[4];
    assign o_col2_z = cols[5];
    assign o_col3_x = cols[6];
    assign o_col3_y = cols[7];
    assign o_col3_z = cols[8];

endmodule
